// ===== rtl/core/jrg_pkg.sv =====
// jrg_pkg: shared widths, constants and beat types of the jacobi rotation generator
// no dependencies; used by every file under rtl/core
package jrg_pkg;

	localparam int IN_W      = 32;             // input field width
	localparam int OUT_W     = 32;             // cosine / sine width
	localparam int OUT_FRAC  = 30;             // fraction bits of cosine / sine
	localparam int THR_W     = 16;             // zero_threshold width
	localparam int APB_DW    = 32;             // apb data width
	localparam int APB_AW    = 3;              // apb address width

	localparam int DIFF_W    = IN_W + 1;       // diagonal difference, doubled off-diagonal
	localparam int NORM_W    = IN_W - 1;       // operands after normalization
	localparam int SQ_W      = 2 * NORM_W;     // one square
	localparam int SUM_W     = SQ_W + 1;       // sum of two squares
	localparam int SQ1_ROOT  = (SUM_W + 1) / 2;
	localparam int DEN1_W    = SQ1_ROOT + 1;   // |d| plus root
	localparam int T_W       = OUT_FRAC + 1;   // t, at most one
	localparam int NUM_W     = NORM_W + OUT_FRAC;
	localparam int ARG_W     = 2 * OUT_FRAC + 2;
	localparam int SQ2_ROOT  = ARG_W / 2;
	localparam int C_W       = OUT_FRAC + 1;   // cosine magnitude, at most one

	localparam logic [T_W-1:0]   T_ONE   = T_W'(1) << OUT_FRAC;
	localparam logic [ARG_W-1:0] ONE_SQ  = ARG_W'(1) << (2 * OUT_FRAC);
	localparam logic [NUM_W-1:0] NUM_ONE = NUM_W'(1) << (2 * OUT_FRAC);

	// register map, word index
	localparam logic [0:0] REG_ZERO_THRESHOLD = 1'b0;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

	typedef struct packed {
		logic signed [IN_W-1:0] diag_first;
		logic signed [IN_W-1:0] diag_second;
		logic signed [IN_W-1:0] off_diag;
	} in_beat_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] cosine;
		logic signed [OUT_W-1:0] sine;
		logic                    was_skipped;
	} out_beat_t;

endpackage

// ===== rtl/core/jrg_isqrt_pipe.sv =====
// jrg_isqrt_pipe: floor square root, one root bit per pipeline stage
// depends on jrg_pkg for default widths
module jrg_isqrt_pipe #(
	parameter int ROOT_W = jrg_pkg::SQ1_ROOT,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [2*ROOT_W-1:0] radicand,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                out_valid,
	output logic [ROOT_W-1:0]   root,
	output logic [SIDE_W-1:0]   side_out
);

	localparam int X_W   = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic              vld_s  [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [X_W-1:0]    x_s    [ROOT_W];
	logic [SIDE_W-1:0] side_s [ROOT_W];

	logic [REM_W-1:0]  rem_nx  [ROOT_W];
	logic [ROOT_W-1:0] root_nx [ROOT_W];
	logic [X_W-1:0]    x_nx    [ROOT_W];

	always_comb begin
		logic [REM_W-1:0]  rem_cur;
		logic [ROOT_W-1:0] root_cur;
		logic [X_W-1:0]    x_cur;
		logic [REM_W-1:0]  shifted;
		logic [REM_W-1:0]  trial;
		for (int k = 0; k < ROOT_W; k++) begin
			if (k == 0) begin
				rem_cur  = '0;
				root_cur = '0;
				x_cur    = radicand;
			end else begin
				rem_cur  = rem_s[k-1];
				root_cur = root_s[k-1];
				x_cur    = x_s[k-1];
			end
			// bring down two radicand bits, try root*4+1
			shifted = {rem_cur[ROOT_W-1:0], x_cur[X_W-1 -: 2]};
			trial   = {root_cur, 2'b01};
			if (shifted >= trial) begin
				rem_nx[k]  = shifted - trial;
				root_nx[k] = {root_cur[ROOT_W-2:0], 1'b1};
			end else begin
				rem_nx[k]  = shifted;
				root_nx[k] = {root_cur[ROOT_W-2:0], 1'b0};
			end
			x_nx[k] = {x_cur[X_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOT_W; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < ROOT_W; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ROOT_W; k++) begin
				rem_s[k]  <= rem_nx[k];
				root_s[k] <= root_nx[k];
				x_s[k]    <= x_nx[k];
			end
			side_s[0] <= side_in;
			for (int k = 1; k < ROOT_W; k++) side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign side_out  = side_s[ROOT_W-1];

endmodule

// ===== rtl/core/jrg_div_pipe.sv =====
// jrg_div_pipe: restoring unsigned divider, one quotient bit per pipeline stage
// depends on jrg_pkg for default widths; quotient must fit in QUO_W bits
module jrg_div_pipe #(
	parameter int NUM_W  = jrg_pkg::NUM_W,
	parameter int DEN_W  = jrg_pkg::DEN1_W,
	parameter int QUO_W  = jrg_pkg::T_W,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  dividend,
	input  logic [DEN_W-1:0]  divisor,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quotient,
	output logic [SIDE_W-1:0] side_out
);

	logic              vld_s  [QUO_W];
	logic [DEN_W-1:0]  rem_s  [QUO_W];
	logic [DEN_W-1:0]  den_s  [QUO_W];
	logic [QUO_W-1:0]  low_s  [QUO_W];
	logic [QUO_W-1:0]  quo_s  [QUO_W];
	logic [SIDE_W-1:0] side_s [QUO_W];

	logic [DEN_W-1:0] rem_nx [QUO_W];
	logic [QUO_W-1:0] low_nx [QUO_W];
	logic [QUO_W-1:0] quo_nx [QUO_W];

	always_comb begin
		logic [DEN_W-1:0] rem_cur;
		logic [DEN_W-1:0] den_cur;
		logic [QUO_W-1:0] low_cur;
		logic [QUO_W-1:0] quo_cur;
		logic [DEN_W:0]   shifted;
		for (int k = 0; k < QUO_W; k++) begin
			if (k == 0) begin
				// upper dividend bits start below the divisor
				rem_cur = DEN_W'(dividend[NUM_W-1:QUO_W]);
				den_cur = divisor;
				low_cur = dividend[QUO_W-1:0];
				quo_cur = '0;
			end else begin
				rem_cur = rem_s[k-1];
				den_cur = den_s[k-1];
				low_cur = low_s[k-1];
				quo_cur = quo_s[k-1];
			end
			shifted = {rem_cur, low_cur[QUO_W-1]};
			if (shifted >= {1'b0, den_cur}) begin
				rem_nx[k] = DEN_W'(shifted - {1'b0, den_cur});
				quo_nx[k] = {quo_cur[QUO_W-2:0], 1'b1};
			end else begin
				rem_nx[k] = DEN_W'(shifted);
				quo_nx[k] = {quo_cur[QUO_W-2:0], 1'b0};
			end
			low_nx[k] = {low_cur[QUO_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QUO_W; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < QUO_W; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QUO_W; k++) begin
				rem_s[k] <= rem_nx[k];
				low_s[k] <= low_nx[k];
				quo_s[k] <= quo_nx[k];
			end
			den_s[0]  <= divisor;
			side_s[0] <= side_in;
			for (int k = 1; k < QUO_W; k++) begin
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[QUO_W-1];
	assign quotient  = quo_s[QUO_W-1];
	assign side_out  = side_s[QUO_W-1];

endmodule

// ===== rtl/core/jacobi_rotation_generator.sv =====
// jacobi_rotation_generator: pipelined 2x2 symmetric schur rotation (cosine, sine)
// depends on jrg_pkg, jrg_isqrt_pipe, jrg_div_pipe
//
//  channel | signals                               | beat
//  --------+---------------------------------------+---------------------------------
//  in      | in_valid, in_ready, in_data           | diag_first, diag_second, off_diag
//  out     | out_valid, out_ready, out_data        | cosine, sine, was_skipped
//  cfg     | psel penable pwrite paddr pwdata ...  | zero_threshold at byte address 0
//
//  one beat per cycle sustained unless the output beat waits; most stages lie in the two square root units
//  (32 and 31 stages) and the two dividers (31 stages each), one result bit per stage
//  arst_n clears all stage valid bits and loads zero_threshold with 1; no clearing pass
//  a single enable moves every stage; it drops only while the output beat waits,
//  and then every stage holds, full or empty, and in_ready stays low
module jacobi_rotation_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  jrg_pkg::in_beat_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output jrg_pkg::out_beat_t            out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [jrg_pkg::APB_AW-1:0]    paddr,
	input  logic [jrg_pkg::APB_DW-1:0]    pwdata,
	output logic [jrg_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	localparam int DW  = jrg_pkg::DIFF_W;
	localparam int NW  = jrg_pkg::NORM_W;
	localparam int TW  = jrg_pkg::T_W;
	localparam int CW  = jrg_pkg::C_W;
	localparam int R1  = jrg_pkg::SQ1_ROOT;
	localparam int R2  = jrg_pkg::SQ2_ROOT;
	localparam int OF  = jrg_pkg::OUT_FRAC;
	localparam int SB1 = 2 + 2 * NW;     // skip, neg, |d|, |e|
	localparam int SB2 = 3;              // skip, neg, zero divisor
	localparam int SB3 = 2 + TW;         // skip, neg, t

	// ---------------- configuration register ----------------
	logic [jrg_pkg::THR_W-1:0] thr_q;
	logic                      reg_hit;

	assign reg_hit = (paddr[2] == jrg_pkg::REG_ZERO_THRESHOLD);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? jrg_pkg::APB_DW'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= jrg_pkg::THR_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			thr_q <= pwdata[jrg_pkg::THR_W-1:0];
		end
	end

	// ---------------- global stage enable ----------------
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: diagonal difference, latch off-diagonal
	logic                 v_s1;
	logic signed [DW-1:0] d_s1;
	logic signed [jrg_pkg::IN_W-1:0] aij_s1;

	// stage 2: magnitudes, threshold test, sign of t
	logic          v_s2, skip_s2, neg_s2;
	logic [DW-1:0] ad_s2, ae_s2;

	// stage 3: common right shift until both fit in NW bits
	logic          v_s3, skip_s3, neg_s3;
	logic [NW-1:0] ad_s3, ae_s3;

	// stage 4: squares
	logic                        v_s4, skip_s4, neg_s4;
	logic [NW-1:0]               ad_s4, ae_s4;
	logic [jrg_pkg::SQ_W-1:0]    adsq_s4, aesq_s4;

	// stage 5: sum of squares
	logic                        v_s5, skip_s5, neg_s5;
	logic [NW-1:0]               ad_s5, ae_s5;
	logic [jrg_pkg::SUM_W-1:0]   sum_s5;

	logic            sq1_v;
	logic [R1-1:0]   sq1_root;
	logic [SB1-1:0]  sq1_side;

	// stage 6: divisor |d| + root, dividend |e| << OF
	logic                          v_s6, skip_s6, neg_s6;
	logic [jrg_pkg::DEN1_W-1:0]    den_s6;
	logic [jrg_pkg::NUM_W-1:0]     num_s6;

	logic            dv1_v;
	logic [TW-1:0]   dv1_quo;
	logic [SB2-1:0]  dv1_side;

	// stage 7: t, zero divisor gives zero, clamp to one
	logic          v_s7, skip_s7, neg_s7;
	logic [TW-1:0] t_s7;

	// stage 8: t squared
	logic                    v_s8, skip_s8, neg_s8;
	logic [TW-1:0]           t_s8;
	logic [2*TW-1:0]         tsq_s8;

	// stage 9: one plus t squared
	logic                         v_s9, skip_s9, neg_s9;
	logic [TW-1:0]                t_s9;
	logic [jrg_pkg::ARG_W-1:0]    arg_s9;

	logic            sq2_v;
	logic [R2-1:0]   sq2_root;
	logic [SB3-1:0]  sq2_side;

	logic            dv2_v;
	logic [CW-1:0]   dv2_quo;
	logic [SB3-1:0]  dv2_side;

	// stage 10: t * c
	logic                 v_s10, skip_s10, neg_s10;
	logic [CW-1:0]        c_s10;
	logic [TW+CW-1:0]     prod_s10;

	// output register
	logic               out_v_q;
	jrg_pkg::out_beat_t out_q;

	// ---------------- valid chain ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			v_s8    <= 1'b0;
			v_s9    <= 1'b0;
			v_s10   <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= sq1_v;
			v_s7    <= dv1_v;
			v_s8    <= v_s7;
			v_s9    <= v_s8;
			v_s10   <= dv2_v;
			out_v_q <= v_s10;
		end
	end

	// ---------------- front end ----------------
	logic          d_neg;
	logic [DW-1:0] ad_c, am_c;

	assign d_neg = d_s1[DW-1];
	assign ad_c  = d_neg ? (DW'(0) - DW'(d_s1)) : DW'(d_s1);
	// |aij| fits IN_W bits unsigned, including the most negative input
	assign am_c  = {1'b0, (aij_s1[jrg_pkg::IN_W-1] ?
		(jrg_pkg::IN_W'(0) - jrg_pkg::IN_W'(aij_s1)) : jrg_pkg::IN_W'(aij_s1))};

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1   <= DW'(in_data.diag_second) - DW'(in_data.diag_first);
			aij_s1 <= in_data.off_diag;

			ad_s2   <= ad_c;
			ae_s2   <= {am_c[DW-2:0], 1'b0};
			skip_s2 <= am_c < DW'(thr_q);
			// t negative when d and aij differ in sign; d of zero always gives a positive t
			neg_s2  <= (d_s1 != '0) && (d_neg != aij_s1[jrg_pkg::IN_W-1]);

			skip_s3 <= skip_s2;
			neg_s3  <= neg_s2;
			if (ad_s2[DW-1] || ae_s2[DW-1]) begin
				ad_s3 <= NW'(ad_s2 >> 2);
				ae_s3 <= NW'(ae_s2 >> 2);
			end else if (ad_s2[DW-2] || ae_s2[DW-2]) begin
				ad_s3 <= NW'(ad_s2 >> 1);
				ae_s3 <= NW'(ae_s2 >> 1);
			end else begin
				ad_s3 <= NW'(ad_s2);
				ae_s3 <= NW'(ae_s2);
			end

			skip_s4 <= skip_s3;
			neg_s4  <= neg_s3;
			ad_s4   <= ad_s3;
			ae_s4   <= ae_s3;
			adsq_s4 <= jrg_pkg::SQ_W'(ad_s3) * jrg_pkg::SQ_W'(ad_s3);
			aesq_s4 <= jrg_pkg::SQ_W'(ae_s3) * jrg_pkg::SQ_W'(ae_s3);

			skip_s5 <= skip_s4;
			neg_s5  <= neg_s4;
			ad_s5   <= ad_s4;
			ae_s5   <= ae_s4;
			sum_s5  <= jrg_pkg::SUM_W'(adsq_s4) + jrg_pkg::SUM_W'(aesq_s4);
		end
	end

	// sqrt(|d|^2 + |e|^2)
	jrg_isqrt_pipe #(
		.ROOT_W (R1),
		.SIDE_W (SB1)
	) u_sqrt_hyp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.radicand  ((2*R1)'(sum_s5)),
		.side_in   ({skip_s5, neg_s5, ad_s5, ae_s5}),
		.out_valid (sq1_v),
		.root      (sq1_root),
		.side_out  (sq1_side)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			skip_s6 <= sq1_side[SB1-1];
			neg_s6  <= sq1_side[SB1-2];
			den_s6  <= jrg_pkg::DEN1_W'(sq1_side[2*NW-1:NW]) + jrg_pkg::DEN1_W'(sq1_root);
			num_s6  <= {sq1_side[NW-1:0], OF'(0)};
		end
	end

	// t = |e| / (|d| + root)
	jrg_div_pipe #(
		.NUM_W  (jrg_pkg::NUM_W),
		.DEN_W  (jrg_pkg::DEN1_W),
		.QUO_W  (TW),
		.SIDE_W (SB2)
	) u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.dividend  (num_s6),
		.divisor   (den_s6),
		.side_in   ({skip_s6, neg_s6, den_s6 == '0}),
		.out_valid (dv1_v),
		.quotient  (dv1_quo),
		.side_out  (dv1_side)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			skip_s7 <= dv1_side[2];
			neg_s7  <= dv1_side[1];
			if (dv1_side[0]) begin
				t_s7 <= '0;
			end else if (dv1_quo > jrg_pkg::T_ONE) begin
				t_s7 <= jrg_pkg::T_ONE;
			end else begin
				t_s7 <= dv1_quo;
			end

			skip_s8 <= skip_s7;
			neg_s8  <= neg_s7;
			t_s8    <= t_s7;
			tsq_s8  <= (2*TW)'(t_s7) * (2*TW)'(t_s7);

			skip_s9 <= skip_s8;
			neg_s9  <= neg_s8;
			t_s9    <= t_s8;
			arg_s9  <= jrg_pkg::ONE_SQ + jrg_pkg::ARG_W'(tsq_s8);
		end
	end

	// q = sqrt(1 + t^2), scaled
	jrg_isqrt_pipe #(
		.ROOT_W (R2),
		.SIDE_W (SB3)
	) u_sqrt_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s9),
		.radicand  ((2*R2)'(arg_s9)),
		.side_in   ({skip_s9, neg_s9, t_s9}),
		.out_valid (sq2_v),
		.root      (sq2_root),
		.side_out  (sq2_side)
	);

	// c = 1 / q
	jrg_div_pipe #(
		.NUM_W  (jrg_pkg::NUM_W),
		.DEN_W  (R2),
		.QUO_W  (CW),
		.SIDE_W (SB3)
	) u_div_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq2_v),
		.dividend  (jrg_pkg::NUM_ONE),
		.divisor   (sq2_root),
		.side_in   (sq2_side),
		.out_valid (dv2_v),
		.quotient  (dv2_quo),
		.side_out  (dv2_side)
	);

	// s = t * c, then sign and identity override into the output beat
	logic [jrg_pkg::OUT_W-1:0] s_mag;
	assign s_mag = prod_s10[OF +: jrg_pkg::OUT_W];

	always_ff @(posedge clk) begin
		if (en) begin
			skip_s10 <= dv2_side[SB3-1];
			neg_s10  <= dv2_side[SB3-2];
			c_s10    <= dv2_quo;
			prod_s10 <= (TW+CW)'(dv2_side[TW-1:0]) * (TW+CW)'(dv2_quo);

			out_q.was_skipped <= skip_s10;
			if (skip_s10) begin
				out_q.cosine <= jrg_pkg::OUT_W'(jrg_pkg::T_ONE);
				out_q.sine   <= '0;
			end else begin
				out_q.cosine <= jrg_pkg::OUT_W'(c_s10);
				out_q.sine   <= neg_s10 ? (jrg_pkg::OUT_W'(0) - s_mag) : s_mag;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// ---------------- assertions ----------------
	logic signed [jrg_pkg::OUT_W-1:0] one_fix;
	assign one_fix = jrg_pkg::OUT_W'(jrg_pkg::T_ONE);

	a_skip_identity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.was_skipped |-> out_data.cosine == one_fix && out_data.sine == '0)
		else $error("skipped beat is not the identity rotation");

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.cosine <= one_fix && out_data.cosine > 0)
		else $error("cosine out of (0, 1]");

	a_sin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.sine <= out_data.cosine && -out_data.sine <= out_data.cosine)
		else $error("sine magnitude above cosine");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("pipeline stalled without a waiting output beat");

endmodule
